// ----- rtl/core/assert_macros.svh -----
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off during reset.
`define ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, off during reset.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/bbpa_pkg.sv -----
package bbpa_pkg;

  localparam int MAX_BLOCKS    = 1024;
  localparam int MAP_WORD_BITS = 32;
  localparam int MAP_WORDS     = (MAX_BLOCKS + MAP_WORD_BITS - 1) / MAP_WORD_BITS;
  localparam int MAP_AW        = $clog2(MAP_WORDS);
  localparam int BIT_W         = $clog2(MAP_WORD_BITS);
  localparam int IDX_W         = MAP_AW + BIT_W;

  localparam int ADDR_W        = 32;
  localparam int SIZE_W        = 13;
  localparam int COUNT_W       = 11;
  localparam int NUM_W         = 10;
  localparam int STATUS_W      = 2;
  localparam int PROD_W        = COUNT_W + SIZE_W;
  localparam int OUT_DATA_W    = ((ADDR_W + NUM_W + 7) / 8) * 8;

  localparam int CFG_IDX_W     = 2;
  localparam int CFG_DATA_W    = 32;

  localparam int SIZE_MIN      = 8;
  localparam int SIZE_CEIL     = 4096;
  localparam int SIZE_ALIGN    = 8;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_RANGE = 2'd2
  } status_t;

  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_POOL_BASE = 2'd0,
    CFG_BLK_BYTES = 2'd1,
    CFG_BLK_TOTAL = 2'd2
  } cfg_reg_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN,
    S_MUL,
    S_ADD,
    S_RCHK,
    S_DIV,
    S_FREE_RD,
    S_FREE_WR,
    S_DONE
  } state_t;

  // One map access per cycle: a read address and an optional write.
  typedef struct packed {
    logic                     wr;
    logic [MAP_AW-1:0]        waddr;
    logic [MAP_WORD_BITS-1:0] wdata;
    logic [MAP_AW-1:0]        raddr;
  } map_req_t;

endpackage

// ----- rtl/core/bbpa_ram.sv -----
module bbpa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/core/bbpa_map.sv -----
// Used-bit map: word RAM plus one valid flop per word, so reset reads as all clear.
module bbpa_map import bbpa_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  map_req_t                 req,
  output logic [MAP_WORD_BITS-1:0] rd_data
);

  logic [MAP_WORDS-1:0]     valid;
  logic                     rd_valid;
  logic [MAP_WORD_BITS-1:0] ram_q;

  bbpa_ram #(
    .WIDTH (MAP_WORD_BITS),
    .DEPTH (MAP_WORDS)
  ) u_ram (
    .clk   (clk),
    .we    (req.wr),
    .waddr (req.waddr),
    .wdata (req.wdata),
    .raddr (req.raddr),
    .rdata (ram_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (req.wr) begin
      valid[req.waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    rd_valid <= valid[req.raddr];
  end

  assign rd_data = rd_valid ? ram_q : '0;

endmodule

// ----- rtl/core/bbpa_div.sv -----
`include "assert_macros.svh"

// Shift-subtract divider, one quotient bit per cycle.
// Caller guarantees dividend < divisor << IDX_W.
module bbpa_div import bbpa_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [PROD_W-1:0] dividend,
  input  logic [SIZE_W-1:0] divisor,
  output logic              busy,
  output logic              done,
  output logic [IDX_W-1:0]  quot,
  output logic [SIZE_W-1:0] rem
);

  localparam int STEP_W = $clog2(IDX_W);

  logic [STEP_W-1:0] cnt;
  logic [PROD_W-1:0] rem_r;
  logic [PROD_W-1:0] dsh;
  logic [IDX_W-1:0]  q;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= STEP_W'(IDX_W - 1);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= dividend;
      dsh   <= PROD_W'(divisor) << (IDX_W - 1);
      q     <= '0;
    end else if (busy) begin
      if (rem_r >= dsh) begin
        rem_r <= rem_r - dsh;
        q     <= {q[IDX_W-2:0], 1'b1};
      end else begin
        q     <= {q[IDX_W-2:0], 1'b0};
      end
      dsh <= dsh >> 1;
    end
  end

  assign quot = q;
  assign rem  = rem_r[SIZE_W-1:0];

  `ASSERT_IMPL(div_done_ends_run, clk, rst, done, $past(busy) && !busy, "div done without run")

endmodule

// ----- rtl/core/bitmap_block_pool_allocator.sv -----
// Fixed-size block pool allocator with a used-bit map.
// Input stream: s_axis_tuser = op (0 alloc, 1 free), s_axis_tdata = free_address.
// Output stream: one word per request; tuser = status, tdata = address and number.
// Config: cfg_we/cfg_index/cfg_data, write only while no request is in flight.
//   0 pool base, 1 bytes per block (rounded up to 8, clamped 8..4096),
//   2 blocks in use (clamped to 1024); other indexes are dropped.
// Requests are handled one at a time; s_axis_tready is high only when idle.
// Alloc: scans map words at one word per cycle (registered RAM read, pipelined
//   address), then one multiply and one add.
// Free: range compare after one multiply, a shift-subtract divide (10 quotient
//   bits), then a read-modify-write of one map word; an address out of the pool
//   is answered right after the range compare, with no divide.
// The result sits in an output register; a new request is taken while it waits.
// If the receiver stalls, the next result waits in its final state until the
//   output register frees up.
// Reset: registers go to base 0, size 64, count 128; the map reads all clear at
//   once (valid flop per word), no clearing pass.
module bitmap_block_pool_allocator import bbpa_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  // config write port
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  // request stream
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [ADDR_W-1:0]     s_axis_tdata,   // [31:0] free_address
  input  logic [0:0]            s_axis_tuser,   // [0] op
  // result stream
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0] m_axis_tdata,   // [31:0] block_address, [41:32] block_number
  output logic [STATUS_W-1:0]   m_axis_tuser    // [1:0] status
);

  // config registers
  logic [ADDR_W-1:0]  pool_base;
  logic [SIZE_W-1:0]  blk_bytes;
  logic [COUNT_W-1:0] blk_total;
  logic [SIZE_W:0]    size_rnd;
  logic [SIZE_W-1:0]  blk_bytes_next;
  logic [COUNT_W-1:0] blk_total_next;

  // sequencer
  state_t state, state_next;
  op_t    cur_op;
  logic   in_acc;
  logic   out_free;

  // request datapath
  logic [ADDR_W-1:0]  addr_r;
  logic [ADDR_W-1:0]  offset;
  logic [IDX_W-1:0]   idx_r;
  logic [SIZE_W-1:0]  rem_r;
  logic [MAP_AW-1:0]  rd_ptr;
  logic [MAP_AW-1:0]  chk_w;
  logic               chk_vld;

  // shared multiplier
  logic [COUNT_W-1:0] mul_a;
  logic [PROD_W-1:0]  mul_q;

  // map
  map_req_t                 map_req;
  logic [MAP_WORD_BITS-1:0] word;
  logic                     word_full;
  logic [BIT_W-1:0]         fbit;
  logic [IDX_W-1:0]         found_idx;
  logic                     found_over;
  logic                     last_word;
  logic                     range_bad;

  // divider
  logic              div_start;
  logic              div_busy;
  logic              div_done;
  logic [IDX_W-1:0]  div_quot;
  logic [SIZE_W-1:0] div_rem;

  // pending result
  status_t            res_status;
  logic [ADDR_W-1:0]  res_addr;
  logic [NUM_W-1:0]   res_num;

  assign in_acc   = s_axis_tvalid && s_axis_tready;
  assign out_free = !m_axis_tvalid || m_axis_tready;

  // ---------------- configuration ----------------
  always_comb begin
    size_rnd = ({1'b0, cfg_data[SIZE_W-1:0]} + (SIZE_W+1)'(SIZE_ALIGN - 1))
               & ~(SIZE_W+1)'(SIZE_ALIGN - 1);
    if (size_rnd < (SIZE_W+1)'(SIZE_MIN)) begin
      blk_bytes_next = SIZE_W'(SIZE_MIN);
    end else if (size_rnd > (SIZE_W+1)'(SIZE_CEIL)) begin
      blk_bytes_next = SIZE_W'(SIZE_CEIL);
    end else begin
      blk_bytes_next = size_rnd[SIZE_W-1:0];
    end
    if (cfg_data[COUNT_W-1:0] > COUNT_W'(MAX_BLOCKS)) begin
      blk_total_next = COUNT_W'(MAX_BLOCKS);
    end else begin
      blk_total_next = cfg_data[COUNT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pool_base <= '0;
      blk_bytes <= SIZE_W'(64);
      blk_total <= COUNT_W'(128);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_POOL_BASE: pool_base <= cfg_data[ADDR_W-1:0];
        CFG_BLK_BYTES: blk_bytes <= blk_bytes_next;
        CFG_BLK_TOTAL: blk_total <= blk_total_next;
        default: ;
      endcase
    end
  end

  // ---------------- map and scan ----------------
  bbpa_map u_map (
    .clk     (clk),
    .rst     (rst),
    .req     (map_req),
    .rd_data (word)
  );

  // lowest clear bit of the word under test
  always_comb begin
    fbit = '0;
    for (int i = MAP_WORD_BITS - 1; i >= 0; i--) begin
      if (!word[i]) fbit = BIT_W'(i);
    end
  end

  assign word_full  = &word;
  assign found_idx  = {chk_w, fbit};
  assign found_over = COUNT_W'(found_idx) >= blk_total;
  assign last_word  = chk_w == MAP_AW'(MAP_WORDS - 1);
  assign range_bad  = offset >= ADDR_W'(mul_q);

  // shared multiplier: idx * size for alloc, count * size (pool span) for free
  assign mul_a = (cur_op == OP_ALLOC) ? COUNT_W'(idx_r) : blk_total;

  always_ff @(posedge clk) begin
    mul_q <= PROD_W'(mul_a) * PROD_W'(blk_bytes);
  end

  bbpa_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (offset[PROD_W-1:0]),
    .divisor  (blk_bytes),
    .busy     (div_busy),
    .done     (div_done),
    .quot     (div_quot),
    .rem      (div_rem)
  );

  // ---------------- sequencer ----------------
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_acc) begin
          state_next = (op_t'(s_axis_tuser[0]) == OP_ALLOC) ? S_SCAN : S_MUL;
        end
      end
      S_SCAN: begin
        if (chk_vld && !word_full) begin
          state_next = found_over ? S_DONE : S_MUL;
        end else if (chk_vld && last_word) begin
          state_next = S_DONE;
        end
      end
      S_MUL:     state_next = (cur_op == OP_ALLOC) ? S_ADD : S_RCHK;
      S_ADD:     state_next = S_DONE;
      S_RCHK:    state_next = range_bad ? S_DONE : S_DIV;
      S_DIV: begin
        if (div_done) state_next = S_FREE_RD;
      end
      S_FREE_RD: state_next = S_FREE_WR;
      S_FREE_WR: state_next = S_DONE;
      S_DONE: begin
        if (out_free) state_next = S_IDLE;
      end
      default:   state_next = S_IDLE;
    endcase
  end

  always_comb begin
    s_axis_tready = 1'b0;
    div_start     = 1'b0;
    map_req.wr    = 1'b0;
    map_req.waddr = chk_w;
    map_req.wdata = word | (MAP_WORD_BITS'(1) << fbit);
    map_req.raddr = idx_r[IDX_W-1:BIT_W];
    case (state)
      S_IDLE: s_axis_tready = 1'b1;
      S_SCAN: begin
        map_req.raddr = rd_ptr;
        map_req.wr    = chk_vld && !word_full && !found_over;
      end
      S_RCHK: div_start = !range_bad;
      S_FREE_WR: begin
        map_req.wr    = 1'b1;
        map_req.waddr = idx_r[IDX_W-1:BIT_W];
        map_req.wdata = word & ~(MAP_WORD_BITS'(1) << idx_r[BIT_W-1:0]);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      chk_vld       <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_SCAN) begin
        chk_vld <= 1'b1;
      end else begin
        chk_vld <= 1'b0;
      end
      if (state == S_DONE && out_free) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  // request datapath
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (in_acc) begin
          cur_op <= op_t'(s_axis_tuser[0]);
          addr_r <= s_axis_tdata;
          offset <= s_axis_tdata - pool_base;
          rd_ptr <= '0;
        end
      end
      S_SCAN: begin
        rd_ptr <= rd_ptr + 1'b1;
        chk_w  <= rd_ptr;
        if (chk_vld && !word_full) begin
          idx_r <= found_idx;
        end
        if (chk_vld && (!word_full ? found_over : last_word)) begin
          res_status <= STAT_FULL;
          res_addr   <= '0;
          res_num    <= '0;
        end
      end
      S_ADD: begin
        res_status <= STAT_OK;
        res_addr   <= pool_base + ADDR_W'(mul_q);
        res_num    <= NUM_W'(idx_r);
      end
      S_RCHK: begin
        if (range_bad) begin
          res_status <= STAT_RANGE;
          res_addr   <= '0;
          res_num    <= '0;
        end
      end
      S_DIV: begin
        if (div_done) begin
          idx_r <= div_quot;
          rem_r <= div_rem;
        end
      end
      S_FREE_WR: begin
        // block start = freed address minus its offset within the block
        res_status <= STAT_OK;
        res_addr   <= addr_r - ADDR_W'(rem_r);
        res_num    <= NUM_W'(idx_r);
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (state == S_DONE && out_free) begin
      m_axis_tuser <= res_status;
      m_axis_tdata <= OUT_DATA_W'({res_num, res_addr});
    end
  end

  `ASSERT_IMPL(fail_word_zero, clk, rst, m_axis_tvalid && m_axis_tuser != STAT_OK, m_axis_tdata == '0, "failed result with nonzero payload")

  `ASSERT_IMPL(scan_set_in_pool, clk, rst, state == S_SCAN && map_req.wr, COUNT_W'(found_idx) < blk_total, "scan marks a block beyond the count")

  `ASSERT_IMPL(ok_num_in_pool, clk, rst, m_axis_tvalid && m_axis_tuser == STAT_OK, COUNT_W'(m_axis_tdata[ADDR_W +: NUM_W]) < blk_total, "block number beyond the count")

  `ASSERT_IMPL(div_busy_in_div, clk, rst, div_busy, state == S_DIV, "divider running outside the divide state")

endmodule

// ----- verif/bbpa_alloc_checker.sv -----
`timescale 1ns / 100ps

// Watches config writes and both streams. Keeps its own copy of the pool
// registers and used map, predicts one result word per accepted request word,
// and compares results in order.
module bbpa_alloc_checker import bbpa_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  s_axis_tvalid,
  input  logic                  s_axis_tready,
  input  logic [ADDR_W-1:0]     s_axis_tdata,   // [31:0] free_address
  input  logic [0:0]            s_axis_tuser,   // [0] op
  input  logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  input  logic [OUT_DATA_W-1:0] m_axis_tdata,   // [31:0] block_address, [41:32] block_number
  input  logic [STATUS_W-1:0]   m_axis_tuser,   // [1:0] status
  output int                    fail_count,
  output int                    results_pending,
  output int                    granted_count,
  output int                    full_count,
  output int                    range_count
);

  localparam logic [SIZE_W-1:0]  RST_BLK_BYTES = 13'd64;
  localparam logic [COUNT_W-1:0] RST_BLK_TOTAL = 11'd128;

  typedef struct packed {
    status_t             status;
    logic [ADDR_W-1:0]   addr;
    logic [NUM_W-1:0]    num;
  } pool_result_t;

  logic [MAP_WORD_BITS-1:0] used_words [MAP_WORDS];
  logic [ADDR_W-1:0]        pool_base;
  logic [SIZE_W-1:0]        blk_size;
  logic [COUNT_W-1:0]       blk_count;
  pool_result_t             awaited_results [$];

  initial begin
    fail_count      = 0;
    results_pending = 0;
    granted_count   = 0;
    full_count      = 0;
    range_count     = 0;
  end

  task automatic report_mismatch(string msg);
    $display("[%0t] alloc mismatch: %s", $time, msg);
    fail_count++;
  endtask

  function automatic pool_result_t serve_request(op_t op, logic [ADDR_W-1:0] addr);
    pool_result_t      res;
    logic [ADDR_W-1:0] offset;
    logic [ADDR_W-1:0] span;
    logic [ADDR_W-1:0] idx;
    bit                found;
    res   = '{status: STAT_FULL, addr: '0, num: '0};
    found = 1'b0;
    idx   = '0;
    if (op == OP_ALLOC) begin
      // lowest clear bit below the count; bits past it are never looked at
      for (int i = 0; i < MAX_BLOCKS && !found; i++) begin
        if (i < blk_count && !used_words[i / MAP_WORD_BITS][i % MAP_WORD_BITS]) begin
          used_words[i / MAP_WORD_BITS][i % MAP_WORD_BITS] = 1'b1;
          idx   = i;
          res   = '{status: STAT_OK, addr: pool_base + idx * blk_size,
                    num: idx[NUM_W-1:0]};
          found = 1'b1;
        end
      end
    end else begin
      // offset wraps mod 2^32, so a pool may run past the top of the space
      offset = addr - pool_base;
      span   = blk_count * blk_size;
      if (offset >= span) begin
        res = '{status: STAT_RANGE, addr: '0, num: '0};
      end else begin
        idx = offset / blk_size;
        used_words[idx / MAP_WORD_BITS][idx % MAP_WORD_BITS] = 1'b0;
        res = '{status: STAT_OK, addr: pool_base + idx * blk_size, num: idx[NUM_W-1:0]};
      end
    end
    return res;
  endfunction

  always @(posedge clk) begin : watch
    pool_result_t      got;
    pool_result_t      want;
    logic [31:0]       sz;
    logic [COUNT_W-1:0] cnt;
    if (rst) begin
      foreach (used_words[w])
        used_words[w] = '0;
      pool_base = '0;
      blk_size  = RST_BLK_BYTES;
      blk_count = RST_BLK_TOTAL;
      awaited_results.delete();
      results_pending <= 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_POOL_BASE: pool_base = cfg_data;
          CFG_BLK_BYTES: begin
            sz = cfg_data[SIZE_W-1:0];
            sz = (sz + SIZE_ALIGN - 1) & ~(SIZE_ALIGN - 1);
            if (sz < SIZE_MIN)
              sz = SIZE_MIN;
            if (sz > SIZE_CEIL)
              sz = SIZE_CEIL;
            blk_size = sz[SIZE_W-1:0];
          end
          CFG_BLK_TOTAL: begin
            cnt       = cfg_data[COUNT_W-1:0];
            blk_count = (cnt > MAX_BLOCKS) ? COUNT_W'(MAX_BLOCKS) : cnt;
          end
          default: ;
        endcase
      end

      if (m_axis_tvalid && m_axis_tready) begin
        got.status = status_t'(m_axis_tuser);
        got.addr   = m_axis_tdata[ADDR_W-1:0];
        got.num    = m_axis_tdata[ADDR_W +: NUM_W];
        if (awaited_results.size() == 0) begin
          report_mismatch($sformatf("result word with nothing pending: status %0d addr %h",
                                    got.status, got.addr));
        end else begin
          want = awaited_results.pop_front();
          if (got.status !== want.status)
            report_mismatch($sformatf("status %0d, want %0d", got.status, want.status));
          if (got.addr !== want.addr)
            report_mismatch($sformatf("block_address %h, want %h", got.addr, want.addr));
          if (got.num !== want.num)
            report_mismatch($sformatf("block_number %0d, want %0d", got.num, want.num));
          case (want.status)
            STAT_OK:   granted_count++;
            STAT_FULL: full_count++;
            default:   range_count++;
          endcase
        end
      end

      if (s_axis_tvalid && s_axis_tready)
        awaited_results.push_back(serve_request(op_t'(s_axis_tuser), s_axis_tdata));

      results_pending <= awaited_results.size();
    end
  end

endmodule

// ----- verif/bitmap_block_pool_allocator_tb.sv -----
`timescale 1ns / 100ps

module bitmap_block_pool_allocator_tb import bbpa_pkg::*; ();

  // index 3 is not a register; writes to it must be dropped
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  // Slowest legal run is roughly 2000 words, each with a worst-case scan, send gap
  // and stall; the limit leaves a wide margin.
  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int DRAIN_CYCLES = 60;
  localparam int PHASES       = 8;

  logic                  clk           = 1'b0;
  logic                  rst           = 1'b1;
  logic                  cfg_we        = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index     = '0;
  logic [CFG_DATA_W-1:0] cfg_data      = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [ADDR_W-1:0]     s_axis_tdata  = '0;   // [31:0] free_address
  logic [0:0]            s_axis_tuser  = '0;   // [0] op
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;         // [31:0] block_address, [41:32] block_number
  logic [STATUS_W-1:0]   m_axis_tuser;         // [1:0] status

  int fail_count;
  int results_pending;
  int granted_count;
  int full_count;
  int range_count;

  int cycle_count    = 0;
  int req_count      = 0;
  int settings_count = 0;

  // when set, that side runs back to back with no idle cycles
  bit quiet_tx = 1'b0;
  bit quiet_rx = 1'b0;

  // pool settings as last written, used only to aim free addresses
  logic [31:0] cur_base;
  logic [31:0] cur_size;
  logic [31:0] cur_count;

  always #5 clk = ~clk;

  bitmap_block_pool_allocator uut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  bbpa_alloc_checker alloc_chk (
    .clk             (clk),
    .rst             (rst),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .s_axis_tvalid   (s_axis_tvalid),
    .s_axis_tready   (s_axis_tready),
    .s_axis_tdata    (s_axis_tdata),
    .s_axis_tuser    (s_axis_tuser),
    .m_axis_tvalid   (m_axis_tvalid),
    .m_axis_tready   (m_axis_tready),
    .m_axis_tdata    (m_axis_tdata),
    .m_axis_tuser    (m_axis_tuser),
    .fail_count      (fail_count),
    .results_pending (results_pending),
    .granted_count   (granted_count),
    .full_count      (full_count),
    .range_count     (range_count)
  );

  // Watchdog: a hung handshake or a lost result ends here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still pending",
               cycle_count, results_pending);
      $display("tb: failure");
      $finish;
    end
  end

  // Result side: a fresh random stall before each word, none in quiet stretches.
  // Ready is raised once and held until the word is taken.
  initial begin : result_sink
    int stall;
    while (rst)
      @(posedge clk);
    forever begin
      stall = quiet_rx ? 0 : $urandom_range(0, 13);
      if (stall != 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk); while (!(m_axis_tvalid && m_axis_tready));
    end
  end

  // One request word: optional idle gap, then hold valid until accepted.
  task automatic send_req(op_t op, logic [ADDR_W-1:0] addr);
    int gap;
    gap = quiet_tx ? 0 : $urandom_range(0, 13);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= addr;
    s_axis_tuser  <= op;
    do @(posedge clk); while (!(s_axis_tvalid && s_axis_tready));
    req_count++;
  endtask

  // Stop sending and wait for every predicted result word to come back.
  // Every request yields exactly one result, so the block is idle after this.
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk); while (results_pending != 0);
  endtask

  // Single-cycle register write; only called while idle.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  initial begin : stimulus
    int          items;
    int          alloc_pct;
    int unsigned pick;
    logic [31:0] base;
    logic [31:0] size;
    logic [31:0] count;
    logic [31:0] junk;
    logic [31:0] span;
    logic [31:0] addr;
    op_t         op;

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // ---- directed part ----
    // reset settings: base 0, 64-byte blocks, 128 blocks
    settings_count = 1;
    send_req(OP_ALLOC, $urandom());           // block 0
    send_req(OP_ALLOC, $urandom());           // block 1
    send_req(OP_ALLOC, $urandom());           // block 2
    send_req(OP_FREE, 32'd64 + 32'd37);       // address inside block 1
    send_req(OP_FREE, 32'd64);                // block 1 again: already free, still ok
    send_req(OP_ALLOC, $urandom());           // lowest hole is block 1
    send_req(OP_FREE, 32'd8192);              // one past the pool end
    send_req(OP_FREE, 32'd8191);              // last byte of the last block
    send_req(OP_FREE, 32'hFFFF_FFFF);         // top of address space, outside

    // empty pool: no alloc possible, every free is out of range
    wait_idle();
    write_reg(CFG_BLK_TOTAL, 32'd0);
    settings_count++;
    send_req(OP_ALLOC, $urandom());
    send_req(OP_FREE, 32'd0);

    // count over capacity clamps to 1024, size 0 clamps up to 8
    wait_idle();
    write_reg(CFG_BLK_TOTAL, 32'd2047);
    write_reg(CFG_BLK_BYTES, 32'd0);
    settings_count++;
    send_req(OP_ALLOC, $urandom());           // blocks 0..2 taken, expect 3

    // largest size, pool that crosses 2^32 and wraps to address zero
    wait_idle();
    write_reg(CFG_BLK_BYTES, 32'h0000_1FFF);  // rounds past 4096, clamps
    write_reg(CFG_POOL_BASE, 32'hFFFF_F000);
    settings_count++;
    send_req(OP_FREE, 32'h0000_0010);         // block 1, past the wrap
    send_req(OP_FREE, 32'h003F_EFFF);         // last byte of block 1023
    send_req(OP_FREE, 32'h003F_F000);         // first byte past the pool
    send_req(OP_FREE, 32'hFFFF_EFFF);         // one below the base
    send_req(OP_ALLOC, $urandom());           // block 1 at address 0

    // shrink the count below set bits; junk above the field widths is ignored
    wait_idle();
    write_reg(CFG_POOL_BASE, 32'd0);
    write_reg(CFG_BLK_BYTES, 32'hFFFF_E00D);  // 13 rounds up to 16
    write_reg(CFG_BLK_TOTAL, 32'hFFFF_F802);  // 2 blocks
    settings_count++;
    send_req(OP_ALLOC, $urandom());           // both taken: full
    send_req(OP_FREE, 32'd19);                // block 1
    send_req(OP_ALLOC, $urandom());           // block 1 back

    // write to a missing register, then grow the count over old set bits
    wait_idle();
    write_reg(CFG_UNUSED, 32'hFFFF_FFFF);
    write_reg(CFG_BLK_TOTAL, 32'd4);
    settings_count++;
    send_req(OP_ALLOC, $urandom());           // bit 3 kept from before: full
    send_req(OP_FREE, 32'd48);                // block 3
    send_req(OP_ALLOC, $urandom());           // block 3 again

    // ---- random part ----
    // Phase 0 fills a large map with small blocks so later allocs scan deep
    // words; phase 1 is a one-block pool at the very top of the space.
    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0: begin
          base  = 32'd0;
          size  = SIZE_MIN;
          count = MAX_BLOCKS;
        end
        1: begin
          base  = 32'hFFFF_FFFF;
          size  = SIZE_CEIL;
          count = 1;
        end
        2: begin
          base  = $urandom();
          size  = SIZE_CEIL;
          count = MAX_BLOCKS;
        end
        3: begin
          base  = $urandom();
          size  = SIZE_MIN;
          count = $urandom_range(1, 64);
        end
        default: begin
          base  = $urandom();
          size  = SIZE_ALIGN * $urandom_range(1, SIZE_CEIL / SIZE_ALIGN);
          count = ($urandom_range(0, 3) == 0) ? $urandom_range(1, MAX_BLOCKS)
                                              : $urandom_range(1, 96);
        end
      endcase

      // size is written a little under its target so rounding brings it back;
      // random upper bits must be ignored by the block
      wait_idle();
      junk = $urandom();
      write_reg(CFG_POOL_BASE, base);
      write_reg(CFG_BLK_BYTES, {junk[31:13], 13'(size - $urandom_range(0, 7))});
      write_reg(CFG_BLK_TOTAL, {junk[31:11], 11'(count)});
      if ($urandom_range(0, 1) == 1)
        write_reg(CFG_UNUSED, $urandom());
      settings_count++;
      cur_base  = base;
      cur_size  = size;
      cur_count = count;

      items     = (phase == 0) ? 700 : (phase == 2) ? 250 : 165;
      alloc_pct = (phase == 0) ? 95 : (phase == 2) ? 85 : $urandom_range(35, 85);

      for (int n = 0; n < items; n++) begin
        // redraw idle modes now and then so both busy and quiet stretches occur
        if (n % 50 == 0) begin
          quiet_tx = ($urandom_range(0, 3) == 0);
          quiet_rx = ($urandom_range(0, 3) == 0);
        end
        // occasional full drain in the middle of a phase
        if ($urandom_range(0, 79) == 0)
          wait_idle();

        op   = ($urandom_range(0, 99) < alloc_pct) ? OP_ALLOC : OP_FREE;
        span = cur_count * cur_size;
        pick = $urandom_range(0, 99);
        if (op == OP_ALLOC || pick < 15) begin
          addr = $urandom();
        end else if (pick < 27) begin
          // pool edges, both sides
          case ($urandom_range(0, 3))
            0:       addr = cur_base + span - 1;
            1:       addr = cur_base + span;
            2:       addr = cur_base - 1;
            default: addr = cur_base;
          endcase
        end else begin
          // any byte inside a random block of the pool
          addr = cur_base + $urandom_range(0, cur_count - 1) * cur_size
                 + $urandom_range(0, cur_size - 1);
        end
        send_req(op, addr);
      end
    end

    // ---- wrap up ----
    quiet_rx = 1'b0;
    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("run: %0d request words across %0d pool settings, with idle, busy and drained stretches",
             req_count, settings_count);
    $display("run: %0d blocks granted or returned, %0d pool-full, %0d out-of-pool answers",
             granted_count, full_count, range_count);
    if (fail_count == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
